// ----- hw/rtl/pfcm_pkg.sv -----
// pfcm_pkg: shared types and codes of the page frame clock manager
`timescale 1ns / 1ps
`default_nettype none
package pfcm_pkg;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] page_id;
        logic [3:0]  frame_index;
        logic [31:0] page_lsn;
    } t_req;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [3:0]  frame_index_res;
        logic [31:0] out_page_id;
        logic        hit;
        logic        need_read;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] eviction_count;
        logic        last;
    } t_res;

    localparam logic [2:0] REQ_FETCH   = 3'd0;
    localparam logic [2:0] REQ_RELEASE = 3'd1;
    localparam logic [2:0] REQ_MARK    = 3'd2;
    localparam logic [2:0] REQ_INSTALL = 3'd3;
    localparam logic [2:0] REQ_FLUSH   = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ALL_PINNED = 3'd1;
    localparam logic [2:0] ST_WAL        = 3'd2;
    localparam logic [2:0] ST_INST_PIN   = 3'd3;
    localparam logic [2:0] ST_FLUSH_PIN  = 3'd4;
    localparam logic [2:0] ST_PIN_OVF    = 3'd5;

    localparam logic KIND_FINAL = 1'b0;
    localparam logic KIND_WB    = 1'b1;

    localparam logic [1:0] ADDR_DURABLE = 2'd0;

    typedef enum logic [4:0] {
        S_IDLE, S_LK_RD, S_LK_CMP, S_HIT, S_SWEEP, S_SW_CHK, S_SW_WB, S_VICTIM,
        S_ALLPIN, S_WAL, S_FR_RD, S_FR_RSP, S_FL_PIN, S_FL_PRSP, S_FL_DRT,
        S_FL_DCHK, S_FL_WB, S_FL_DONE, S_NULL
    } t_state;

endpackage
`default_nettype wire

// ----- hw/rtl/page_frame_clock_manager_top.sv -----
// page_frame_clock_manager_top: frame metadata, clock sweep replacement and flush
`timescale 1ns / 1ps
`default_nettype none
//  channel   direction  handshake              payload
//  request   in         i_in_valid/o_in_stall  i_in_req  (pfcm_pkg::t_req)
//  result    out        o_out_valid/i_out_stall o_out_res (pfcm_pkg::t_res)
//  config    in         apb psel/penable       durable_lsn at address 0
//
//  one request at a time; the tag and lsn memory is read one entry per step
//  lookup reads then compares each frame in turn, up to FRAMES frames
//  a miss sweeps up to 2*FRAMES clock positions, plus a lsn check and a
//  write back for a dirty victim; flush walks the frames twice
//  synchronous active low reset clears flags, pins, hand and counters
//  a stalled result holds every emitting state until it is taken
module page_frame_clock_manager_top #(
    parameter int FRAMES  = 16,
    parameter int PIN_MAX = 255
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  pfcm_pkg::t_req      i_in_req,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output pfcm_pkg::t_res      o_out_res,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [1:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PW = $clog2(PIN_MAX + 1);
    localparam int CW = $clog2(2 * FRAMES + 1);

    // control state
    pfcm_pkg::t_state r_state, n_state;
    pfcm_pkg::t_req   r_req;
    logic [FW-1:0]    r_idx, n_idx;
    logic [FW-1:0]    r_hand, n_hand;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_vwas, n_vwas;
    logic [31:0]      r_durable;
    logic [31:0]      r_hits, n_hits, r_miss, n_miss, r_evict, n_evict;

    // per frame flags and pin counts
    logic          r_valid [FRAMES];
    logic          r_dirty [FRAMES];
    logic          r_ref   [FRAMES];
    logic          r_wr    [FRAMES];
    logic [PW-1:0] r_pins  [FRAMES];

    // tag and lsn memory, registered read at r_idx
    logic [63:0] r_mem [FRAMES];
    logic [63:0] r_rdata;
    logic        r_rd_wr;
    logic        mem_we;
    logic [63:0] mem_wd;

    // flag update for frame r_idx
    logic          flag_we;
    logic          f_valid, f_dirty, f_ref;
    logic [PW-1:0] f_pins;

    // result register
    pfcm_pkg::t_res r_out, res;
    logic           r_ov, out_load, out_free;

    logic        accept;
    logic [31:0] rd_pid, rd_lsn;
    logic        last_idx, fi_ok, match;
    logic [FW-1:0] idx_inc;

    assign pready   = 1'b1;
    assign prdata   = (paddr == pfcm_pkg::ADDR_DURABLE) ? r_durable : 32'd0;

    assign o_in_stall  = (r_state != pfcm_pkg::S_IDLE);
    assign accept      = i_in_valid && (r_state == pfcm_pkg::S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_res   = r_out;
    assign out_free    = !r_ov || !i_out_stall;

    // never written entries read as zero
    assign rd_pid   = r_rd_wr ? r_rdata[63:32] : 32'd0;
    assign rd_lsn   = r_rd_wr ? r_rdata[31:0]  : 32'd0;
    assign last_idx = (32'(r_idx) == 32'(FRAMES - 1));
    assign idx_inc  = last_idx ? '0 : r_idx + FW'(1);
    assign fi_ok    = (32'(i_in_req.frame_index) < 32'(FRAMES));
    assign match    = r_valid[r_idx] && (rd_pid == r_req.page_id);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfcm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_req.req_type)
                        pfcm_pkg::REQ_FETCH,
                        pfcm_pkg::REQ_INSTALL: n_state = pfcm_pkg::S_LK_RD;
                        pfcm_pkg::REQ_RELEASE,
                        pfcm_pkg::REQ_MARK:
                            n_state = fi_ok ? pfcm_pkg::S_FR_RD : pfcm_pkg::S_NULL;
                        pfcm_pkg::REQ_FLUSH: n_state = pfcm_pkg::S_FL_PIN;
                        default:             n_state = pfcm_pkg::S_NULL;
                    endcase
                end
            end
            pfcm_pkg::S_LK_RD: n_state = pfcm_pkg::S_LK_CMP;
            pfcm_pkg::S_LK_CMP: begin
                priority if (match)    n_state = pfcm_pkg::S_HIT;
                else if (last_idx)     n_state = pfcm_pkg::S_SWEEP;
                else                   n_state = pfcm_pkg::S_LK_RD;
            end
            pfcm_pkg::S_SWEEP: begin
                priority if (r_cnt == CW'(2 * FRAMES)) n_state = pfcm_pkg::S_ALLPIN;
                else if (r_pins[r_idx] != '0)          n_state = pfcm_pkg::S_SWEEP;
                else if (r_ref[r_idx])                 n_state = pfcm_pkg::S_SWEEP;
                else if (r_valid[r_idx] && r_dirty[r_idx])
                                                       n_state = pfcm_pkg::S_SW_CHK;
                else                                   n_state = pfcm_pkg::S_VICTIM;
            end
            pfcm_pkg::S_SW_CHK:
                n_state = (rd_lsn > r_durable) ? pfcm_pkg::S_WAL : pfcm_pkg::S_SW_WB;
            pfcm_pkg::S_SW_WB:  if (out_free) n_state = pfcm_pkg::S_VICTIM;
            pfcm_pkg::S_FR_RD:  n_state = pfcm_pkg::S_FR_RSP;
            pfcm_pkg::S_FL_PIN: begin
                priority if (r_pins[r_idx] != '0) n_state = pfcm_pkg::S_FL_PRSP;
                else if (last_idx)                n_state = pfcm_pkg::S_FL_DRT;
                else                              n_state = pfcm_pkg::S_FL_PIN;
            end
            pfcm_pkg::S_FL_DRT: begin
                priority if (r_dirty[r_idx]) n_state = pfcm_pkg::S_FL_DCHK;
                else if (last_idx)           n_state = pfcm_pkg::S_FL_DONE;
                else                         n_state = pfcm_pkg::S_FL_DRT;
            end
            pfcm_pkg::S_FL_DCHK:
                n_state = (rd_lsn > r_durable) ? pfcm_pkg::S_WAL : pfcm_pkg::S_FL_WB;
            pfcm_pkg::S_FL_WB: begin
                if (out_free)
                    n_state = last_idx ? pfcm_pkg::S_FL_DONE : pfcm_pkg::S_FL_DRT;
            end
            pfcm_pkg::S_HIT, pfcm_pkg::S_VICTIM, pfcm_pkg::S_ALLPIN, pfcm_pkg::S_WAL,
            pfcm_pkg::S_FR_RSP, pfcm_pkg::S_FL_PRSP, pfcm_pkg::S_FL_DONE,
            pfcm_pkg::S_NULL: begin
                if (out_free) n_state = pfcm_pkg::S_IDLE;
            end
            default: n_state = pfcm_pkg::S_IDLE;
        endcase
    end

    // datapath actions and results
    always_comb begin
        n_idx    = r_idx;
        n_hand   = r_hand;
        n_cnt    = r_cnt;
        n_vwas   = r_vwas;
        n_hits   = r_hits;
        n_miss   = r_miss;
        n_evict  = r_evict;
        mem_we   = 1'b0;
        mem_wd   = {rd_pid, r_req.page_lsn};
        flag_we  = 1'b0;
        f_valid  = r_valid[r_idx];
        f_dirty  = r_dirty[r_idx];
        f_ref    = r_ref[r_idx];
        f_pins   = r_pins[r_idx];
        out_load = 1'b0;
        res      = '0;
        res.last = 1'b1;
        unique case (r_state)
            pfcm_pkg::S_IDLE: begin
                n_idx = '0;
                if (i_in_valid && fi_ok &&
                    (i_in_req.req_type == pfcm_pkg::REQ_RELEASE ||
                     i_in_req.req_type == pfcm_pkg::REQ_MARK))
                    n_idx = FW'(i_in_req.frame_index);
            end
            pfcm_pkg::S_LK_CMP: begin
                if (!match) begin
                    if (last_idx) begin
                        // miss counted before the sweep
                        if (r_req.req_type == pfcm_pkg::REQ_FETCH)
                            n_miss = r_miss + 32'd1;
                        n_idx = r_hand;
                        n_cnt = '0;
                    end else begin
                        n_idx = idx_inc;
                    end
                end
            end
            pfcm_pkg::S_HIT: begin
                res.frame_index_res = 4'(r_idx);
                res.out_page_id     = r_req.page_id;
                out_load            = out_free;
                if (r_req.req_type == pfcm_pkg::REQ_FETCH) begin
                    res.hit = 1'b1;
                    if (r_pins[r_idx] >= PW'(PIN_MAX)) begin
                        res.status = pfcm_pkg::ST_PIN_OVF;
                    end else if (out_free) begin
                        n_hits  = r_hits + 32'd1;
                        flag_we = 1'b1;
                        f_pins  = r_pins[r_idx] + PW'(1);
                        f_ref   = 1'b1;
                    end
                end else begin
                    if (r_pins[r_idx] != '0) begin
                        res.status = pfcm_pkg::ST_INST_PIN;
                    end else if (out_free) begin
                        mem_we  = 1'b1;
                        mem_wd  = {r_req.page_id, r_req.page_lsn};
                        flag_we = 1'b1;
                        f_valid = 1'b1;
                        f_dirty = 1'b1;
                        f_ref   = 1'b1;
                    end
                end
            end
            pfcm_pkg::S_SWEEP: begin
                if (r_cnt != CW'(2 * FRAMES)) begin
                    n_hand = idx_inc;
                    n_cnt  = r_cnt + CW'(1);
                    n_vwas = r_valid[r_idx];
                    if (r_pins[r_idx] != '0) begin
                        n_idx = idx_inc;
                    end else if (r_ref[r_idx]) begin
                        // second chance
                        flag_we = 1'b1;
                        f_ref   = 1'b0;
                        n_idx   = idx_inc;
                    end
                end
            end
            pfcm_pkg::S_SW_WB: begin
                res.kind            = pfcm_pkg::KIND_WB;
                res.last            = 1'b0;
                res.frame_index_res = 4'(r_idx);
                res.out_page_id     = rd_pid;
                out_load            = out_free;
            end
            pfcm_pkg::S_VICTIM: begin
                res.frame_index_res = 4'(r_idx);
                res.out_page_id     = r_req.page_id;
                out_load            = out_free;
                if (r_req.req_type == pfcm_pkg::REQ_FETCH) begin
                    res.need_read = 1'b1;
                    mem_wd        = {r_req.page_id, 32'd0};
                    f_dirty       = 1'b0;
                    f_pins        = PW'(1);
                end else begin
                    mem_wd        = {r_req.page_id, r_req.page_lsn};
                    f_dirty       = 1'b1;
                end
                f_valid = 1'b1;
                f_ref   = 1'b1;
                if (out_free) begin
                    mem_we  = 1'b1;
                    flag_we = 1'b1;
                    if (r_vwas) n_evict = r_evict + 32'd1;
                end
            end
            pfcm_pkg::S_ALLPIN: begin
                res.status = pfcm_pkg::ST_ALL_PINNED;
                out_load   = out_free;
            end
            pfcm_pkg::S_WAL: begin
                res.status          = pfcm_pkg::ST_WAL;
                res.frame_index_res = 4'(r_idx);
                res.out_page_id     = rd_pid;
                out_load            = out_free;
            end
            pfcm_pkg::S_FR_RSP: begin
                res.frame_index_res = r_req.frame_index;
                res.out_page_id     = rd_pid;
                out_load            = out_free;
                if (out_free) begin
                    if (r_req.req_type == pfcm_pkg::REQ_RELEASE) begin
                        flag_we = 1'b1;
                        if (r_pins[r_idx] != '0) f_pins = r_pins[r_idx] - PW'(1);
                    end else if (r_valid[r_idx]) begin
                        mem_we  = 1'b1;
                        flag_we = 1'b1;
                        f_dirty = 1'b1;
                    end
                end
            end
            pfcm_pkg::S_FL_PIN: begin
                if (r_pins[r_idx] == '0) n_idx = idx_inc;
            end
            pfcm_pkg::S_FL_PRSP: begin
                res.status          = pfcm_pkg::ST_FLUSH_PIN;
                res.frame_index_res = 4'(r_idx);
                res.out_page_id     = rd_pid;
                out_load            = out_free;
            end
            pfcm_pkg::S_FL_DRT: begin
                if (!r_dirty[r_idx] && !last_idx) n_idx = idx_inc;
            end
            pfcm_pkg::S_FL_WB: begin
                res.kind            = pfcm_pkg::KIND_WB;
                res.last            = 1'b0;
                res.frame_index_res = 4'(r_idx);
                res.out_page_id     = rd_pid;
                out_load            = out_free;
                if (out_free) begin
                    flag_we = 1'b1;
                    f_dirty = 1'b0;
                    if (!last_idx) n_idx = idx_inc;
                end
            end
            pfcm_pkg::S_FL_DONE: out_load = out_free;
            pfcm_pkg::S_NULL: begin
                if (r_req.req_type == pfcm_pkg::REQ_RELEASE ||
                    r_req.req_type == pfcm_pkg::REQ_MARK)
                    res.frame_index_res = r_req.frame_index;
                out_load = out_free;
            end
            pfcm_pkg::S_LK_RD, pfcm_pkg::S_SW_CHK, pfcm_pkg::S_FR_RD,
            pfcm_pkg::S_FL_DCHK: begin
            end
            default: begin
            end
        endcase
        // counters shown after this step's update
        res.hit_count      = n_hits;
        res.miss_count     = n_miss;
        res.eviction_count = n_evict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pfcm_pkg::S_IDLE;
            r_idx     <= '0;
            r_hand    <= '0;
            r_cnt     <= '0;
            r_vwas    <= 1'b0;
            r_durable <= '0;
            r_hits    <= '0;
            r_miss    <= '0;
            r_evict   <= '0;
            r_ov      <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                r_valid[i] <= 1'b0;
                r_dirty[i] <= 1'b0;
                r_ref[i]   <= 1'b0;
                r_wr[i]    <= 1'b0;
                r_pins[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_hand  <= n_hand;
            r_cnt   <= n_cnt;
            r_vwas  <= n_vwas;
            r_hits  <= n_hits;
            r_miss  <= n_miss;
            r_evict <= n_evict;
            r_ov    <= out_load || (r_ov && i_out_stall);
            if (psel && penable && pwrite && paddr == pfcm_pkg::ADDR_DURABLE)
                r_durable <= pwdata;
            if (flag_we) begin
                r_valid[r_idx] <= f_valid;
                r_dirty[r_idx] <= f_dirty;
                r_ref[r_idx]   <= f_ref;
                r_pins[r_idx]  <= f_pins;
            end
            if (mem_we) r_wr[r_idx] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept)   r_req <= i_in_req;
        if (out_load) r_out <= res;
    end

    // tag and lsn memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_idx] <= mem_wd;
        r_rdata <= r_mem[r_idx];
        r_rd_wr <= r_wr[r_idx] || mem_we;
    end

endmodule
`default_nettype wire
